FILE: hw/rtl/npmac_pkg.sv
// Package for the negacyclic polynomial multiply-accumulate block (mod 8191).
// Holds sizes, the sequencer state type and the structs passed to and from the multiply-reduce unit.
package npmac_pkg;

  localparam int POLY_DEGREE = 16;
  localparam int IDX_W       = $clog2(POLY_DEGREE);
  localparam int CNT_W       = $clog2(POLY_DEGREE + 1);
  localparam int COEF_W      = 14;
  localparam int SUM_W       = 13;
  localparam int PROD_W      = 2 * COEF_W;

  localparam logic [SUM_W-1:0] MOD_Q = 13'd8191;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MAC,
    ST_DRAIN,
    ST_EMIT
  } npmac_state_t;

  typedef struct packed {
    logic                     vld;
    logic signed [COEF_W-1:0] a;
    logic signed [COEF_W-1:0] b;
    logic [IDX_W-1:0]         k;
    logic                     wrap;
  } mac_op_t;

  typedef struct packed {
    logic             pend;
    logic             vld;
    logic             sub;
    logic [IDX_W-1:0] k;
    logic [SUM_W-1:0] val;
  } mac_res_t;

endpackage

FILE: hw/rtl/npmac_ifs.sv
// Valid/ready channel interfaces for coefficient items in and result items out.
// Depends on npmac_pkg for field widths.
interface npmac_in_if;
  import npmac_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [COEF_W-1:0] first_coef;
  logic signed [COEF_W-1:0] second_coef;
  logic                     last_term;

  modport source (output valid, output first_coef, output second_coef, output last_term,
                  input ready);
  modport sink (input valid, input first_coef, input second_coef, input last_term,
                output ready);
endinterface

interface npmac_out_if;
  import npmac_pkg::*;

  logic             valid;
  logic             ready;
  logic [SUM_W-1:0] sum_coef;
  logic             sum_last;

  modport source (output valid, output sum_coef, output sum_last, input ready);
  modport sink (input valid, input sum_coef, input sum_last, output ready);
endinterface

FILE: hw/rtl/npmac_mulred.sv
// Shared multiply-reduce unit: signed 14x14 product, then reduction mod 2^13-1.
// Two register stages; depends on npmac_pkg.
module npmac_mulred (
  input  logic               clk,
  input  logic               rst_n,
  input  npmac_pkg::mac_op_t op,
  output npmac_pkg::mac_res_t res
);
  import npmac_pkg::*;

  logic                     s1_vld_r;
  logic signed [PROD_W-1:0] prod_r;
  logic [IDX_W-1:0]         s1_k_r;
  logic                     s1_wrap_r;

  logic                     s2_vld_r;
  logic                     s2_sub_r;
  logic [IDX_W-1:0]         s2_k_r;
  logic [SUM_W-1:0]         s2_val_r;

  logic signed [PROD_W-1:0] prod_nxt;
  logic [PROD_W-1:0]        mag;
  logic [SUM_W:0]           fold1;
  logic [SUM_W:0]           fold2;
  logic [SUM_W-1:0]         red_nxt;

  assign prod_nxt = PROD_W'(op.a) * PROD_W'(op.b);

  always_comb begin
    mag   = prod_r[PROD_W-1] ? PROD_W'(-prod_r) : PROD_W'(prod_r);
    // 2^13 == 1 and 2^26 == 1 mod q
    fold1 = (SUM_W+1)'(mag[SUM_W-1:0]) + (SUM_W+1)'(mag[2*SUM_W-1:SUM_W])
          + (SUM_W+1)'(mag[2*SUM_W]);
    fold2 = (SUM_W+1)'(fold1[SUM_W-1:0]) + (SUM_W+1)'(fold1[SUM_W]);
    if (fold2 >= (SUM_W+1)'(MOD_Q)) begin
      red_nxt = SUM_W'(fold2 - (SUM_W+1)'(MOD_Q));
    end else begin
      red_nxt = fold2[SUM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= op.vld;
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    prod_r    <= prod_nxt;
    s1_k_r    <= op.k;
    s1_wrap_r <= op.wrap;
    s2_val_r  <= red_nxt;
    s2_sub_r  <= prod_r[PROD_W-1] ^ s1_wrap_r;
    s2_k_r    <= s1_k_r;
  end

  assign res.pend = s1_vld_r;
  assign res.vld  = s2_vld_r;
  assign res.sub  = s2_sub_r;
  assign res.k    = s2_k_r;
  assign res.val  = s2_val_r;

endmodule

FILE: hw/rtl/negacyclic_poly_mac_mod_q.sv
// Negacyclic polynomial multiply-accumulate mod 8191 over Z_8191[x]/(x^N+1), N = POLY_DEGREE.
// Coefficient pairs arrive one per cycle in index order while the block is idle; when a pair is
// complete (N items, or an item with last_term) the block stops taking items and runs the
// schoolbook product through one shared multiply-reduce unit, one product per cycle, folding
// wrapped terms by subtraction. It takes no new items until the products of a pair have drained
// from the multiply-reduce unit. After last_term the N sums are offered one per cycle as the sink
// takes them, sum_last on the final one, and the accumulator is cleared. No clearing pass after
// reset. Depends on npmac_pkg, npmac_ifs and npmac_mulred.
module negacyclic_poly_mac_mod_q (
  input logic       clk,
  input logic       rst_n,
  npmac_in_if.sink  in_ch,
  npmac_out_if.source out_ch
);
  import npmac_pkg::*;

  npmac_state_t state_r, state_nxt;
  logic [IDX_W-1:0] pos_r, pos_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             last_r, last_nxt;
  logic [IDX_W-1:0] i_r, i_nxt;
  logic [IDX_W-1:0] j_r, j_nxt;
  logic [IDX_W-1:0] e_r, e_nxt;

  logic signed [COEF_W-1:0] first_store_r  [POLY_DEGREE];
  logic signed [COEF_W-1:0] second_store_r [POLY_DEGREE];
  logic [SUM_W-1:0]         acc_r          [POLY_DEGREE];
  logic [POLY_DEGREE-1:0]   acc_vld_r;

  logic             in_acc;
  logic             out_acc;
  logic [CNT_W-1:0] pos_inc;
  logic [IDX_W:0]   ksum;
  mac_op_t          op;
  mac_res_t         res;
  logic [IDX_W-1:0] acc_addr;
  logic [SUM_W-1:0] acc_rd;
  logic [SUM_W:0]   acc_sum;
  logic [SUM_W:0]   acc_dif;
  logic [SUM_W-1:0] acc_new;

  assign in_acc  = in_ch.valid & in_ch.ready;
  assign out_acc = out_ch.valid & out_ch.ready;
  assign pos_inc = CNT_W'(pos_r) + CNT_W'(1);

  npmac_mulred u_mulred (
    .clk   (clk),
    .rst_n (rst_n),
    .op    (op),
    .res   (res)
  );

  // Product index i+j, wrapped negacyclically
  always_comb begin
    ksum    = (IDX_W+1)'(i_r) + (IDX_W+1)'(j_r);
    op.vld  = (state_r == ST_MAC);
    op.a    = first_store_r[i_r];
    op.b    = second_store_r[j_r];
    op.wrap = (ksum >= (IDX_W+1)'(POLY_DEGREE));
    op.k    = op.wrap ? IDX_W'(ksum - (IDX_W+1)'(POLY_DEGREE)) : IDX_W'(ksum);
  end

  always_comb begin
    acc_addr = (state_r == ST_EMIT) ? e_r : res.k;
    acc_rd   = acc_vld_r[acc_addr] ? acc_r[acc_addr] : '0;
    acc_sum  = (SUM_W+1)'(acc_rd) + (SUM_W+1)'(res.val);
    acc_dif  = (SUM_W+1)'(acc_rd) - (SUM_W+1)'(res.val);
    if (res.sub) begin
      acc_new = acc_dif[SUM_W] ? SUM_W'(acc_dif + (SUM_W+1)'(MOD_Q)) : acc_dif[SUM_W-1:0];
    end else begin
      acc_new = (acc_sum >= (SUM_W+1)'(MOD_Q)) ? SUM_W'(acc_sum - (SUM_W+1)'(MOD_Q))
                                               : acc_sum[SUM_W-1:0];
    end
  end

  assign in_ch.ready     = (state_r == ST_IDLE);
  assign out_ch.valid    = (state_r == ST_EMIT);
  assign out_ch.sum_coef = acc_rd;
  assign out_ch.sum_last = (e_r == IDX_W'(POLY_DEGREE - 1));

  always_comb begin
    state_nxt = state_r;
    pos_nxt   = pos_r;
    count_nxt = count_r;
    last_nxt  = last_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    e_nxt     = e_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (pos_inc == CNT_W'(POLY_DEGREE) || in_ch.last_term) begin
            count_nxt = pos_inc;
            last_nxt  = in_ch.last_term;
            pos_nxt   = '0;
            i_nxt     = '0;
            j_nxt     = '0;
            state_nxt = ST_MAC;
          end else begin
            pos_nxt = IDX_W'(pos_inc);
          end
        end
      end
      ST_MAC: begin
        if (CNT_W'(j_r) + CNT_W'(1) == count_r) begin
          j_nxt = '0;
          if (CNT_W'(i_r) + CNT_W'(1) == count_r) begin
            state_nxt = ST_DRAIN;
          end else begin
            i_nxt = i_r + IDX_W'(1);
          end
        end else begin
          j_nxt = j_r + IDX_W'(1);
        end
      end
      ST_DRAIN: begin
        if (!res.pend && !res.vld) begin
          e_nxt     = '0;
          state_nxt = last_r ? ST_EMIT : ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (out_acc) begin
          if (out_ch.sum_last) begin
            state_nxt = ST_IDLE;
          end else begin
            e_nxt = e_r + IDX_W'(1);
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      pos_r   <= '0;
      count_r <= '0;
      last_r  <= 1'b0;
      i_r     <= '0;
      j_r     <= '0;
      e_r     <= '0;
    end else begin
      state_r <= state_nxt;
      pos_r   <= pos_nxt;
      count_r <= count_nxt;
      last_r  <= last_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
      e_r     <= e_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      first_store_r[pos_r]  <= in_ch.first_coef;
      second_store_r[pos_r] <= in_ch.second_coef;
    end
    if (res.vld) begin
      acc_r[res.k] <= acc_new;
    end
  end

  // unwritten accumulator entries read as zero; cleared after the final result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_vld_r <= '0;
    end else if (out_acc && out_ch.sum_last) begin
      acc_vld_r <= '0;
    end else if (res.vld) begin
      acc_vld_r[res.k] <= 1'b1;
    end
  end

  a_no_write_in_emit: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_EMIT |-> !res.vld && !res.pend)
    else $error("accumulator update during emission");

  a_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc && out_ch.sum_last |=> state_r == ST_IDLE && acc_vld_r == '0)
    else $error("accumulator not cleared after final result");

  a_sum_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> out_ch.sum_coef < MOD_Q)
    else $error("result out of range");

  a_last_starts_mac: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_ch.last_term |=> state_r == ST_MAC && last_r)
    else $error("last item did not start the fold");

  a_index_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_MAC |-> CNT_W'(i_r) < count_r && CNT_W'(j_r) < count_r)
    else $error("product index beyond pair length");

endmodule
